[rtl/mrp_pkg.sv]
// Shared types and constants for the 32-bit Miller-Rabin prime tester.
`default_nettype none
package mrp_pkg;

    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(DATA_W);
    localparam int WIT_COUNT = 3;
    localparam int WIT_W    = $clog2(WIT_COUNT + 1);

    typedef logic [DATA_W-1:0] word_t;

    // Witnesses that make the test exact for every 32-bit value
    localparam word_t WITNESS [WIT_COUNT] = '{32'd2, 32'd7, 32'd61};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_FACTOR,
        ST_WIT,
        ST_POW,
        ST_POW_MWAIT,
        ST_POW_SQ,
        ST_POW_SWAIT,
        ST_SQR,
        ST_SQR_WAIT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[rtl/mrp_modmul.sv]
// Bit-serial modular multiplier: product = op_a * op_b mod modulus, one bit of op_a per cycle.
`default_nettype none
module mrp_modmul (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire mrp_pkg::word_t op_a,
    input  wire mrp_pkg::word_t op_b,
    input  wire mrp_pkg::word_t modulus,
    output logic               done,
    output mrp_pkg::word_t     product
);
    import mrp_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    word_t             a_reg;
    word_t             b_reg;
    word_t             n_reg;
    word_t             r_reg;
    word_t             r_next;

    logic [DATA_W+1:0] t_sum;
    logic [DATA_W+1:0] t_n;
    logic [DATA_W+1:0] t_2n;

    // r = 2r + bit*b, result below 3n; subtract n or 2n to bring it back under n
    always_comb begin
        t_sum = {1'b0, r_reg, 1'b0} + (a_reg[DATA_W-1] ? {2'b00, b_reg} : '0);
        t_n   = {2'b00, n_reg};
        t_2n  = {1'b0, n_reg, 1'b0};
        if (t_sum >= t_2n) begin
            r_next = DATA_W'(t_sum - t_2n);
        end else if (t_sum >= t_n) begin
            r_next = DATA_W'(t_sum - t_n);
        end else begin
            r_next = DATA_W'(t_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= op_a;
            b_reg <= op_b;
            n_reg <= modulus;
            r_reg <= '0;
        end else if (busy_reg) begin
            a_reg <= {a_reg[DATA_W-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule
`default_nettype wire

[rtl/miller_rabin_prime_test_32.sv]
// Top level of the deterministic Miller-Rabin prime tester for 32-bit numbers.
//
//  channel | ports                          | direction | contents
//  --------+--------------------------------+-----------+---------------------------
//  input   | s_valid, s_ready, s_candidate  | in        | 32-bit unsigned candidate
//  result  | m_valid, m_ready, m_is_prime   | out       | 1 = prime, 0 = not prime
//
// One item at a time. Each modular product is issued by the sequencer and then computed in
// the bit-serial multiplier while the sequencer waits for its done strobe. Only witnesses
// below the candidate are tried (at most 3). Trivial candidates (below 3 or even) go from
// classification straight to the result.
// Reset (aresetn low at a clock edge) drops any test in progress and any pending result.
// A result waiting on m_ready holds the finished verdict; s_ready is high only when no
// test is running, so a new item is taken while the previous result still waits.
`default_nettype none
module miller_rabin_prime_test_32 (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire mrp_pkg::word_t s_candidate,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                m_is_prime
);
    import mrp_pkg::*;

    state_t            state_reg;
    state_t            state_next;

    word_t             n_reg;
    word_t             nm1_reg;
    word_t             d_reg;
    word_t             e_reg;
    word_t             acc_reg;
    word_t             base_reg;
    logic [CNT_W-1:0]  s_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [WIT_W-1:0]  wit_idx_reg;
    logic              verdict_reg;
    logic              m_valid_reg;
    logic              m_is_prime_reg;

    logic              mul_start;
    word_t             mul_a;
    word_t             mul_b;
    logic              mul_done;
    word_t             mul_product;
    logic              out_load;
    word_t             wit_val;

    assign wit_val = (wit_idx_reg < WIT_W'(WIT_COUNT)) ? WITNESS[wit_idx_reg] : '0;

    mrp_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (n_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                if (n_reg < 32'd3 || !n_reg[0]) state_next = ST_DONE;
                else                            state_next = ST_FACTOR;
            end
            ST_FACTOR: begin
                if (d_reg[0]) state_next = ST_WIT;
            end
            ST_WIT: begin
                if (wit_idx_reg == WIT_W'(WIT_COUNT)) state_next = ST_DONE;
                else if (wit_val < n_reg)             state_next = ST_POW;
            end
            ST_POW: begin
                if (e_reg == '0)  state_next = ST_SQR;
                else if (e_reg[0]) state_next = ST_POW_MWAIT;
                else              state_next = ST_POW_SWAIT;
            end
            ST_POW_MWAIT: begin
                if (mul_done) state_next = ST_POW_SQ;
            end
            ST_POW_SQ: begin
                state_next = ST_POW_SWAIT;
            end
            ST_POW_SWAIT: begin
                if (mul_done) state_next = ST_POW;
            end
            ST_SQR: begin
                if (j_reg == s_reg) begin
                    if (acc_reg != 32'd1) state_next = ST_DONE;
                    else                  state_next = ST_WIT;
                end else begin
                    state_next = ST_SQR_WAIT;
                end
            end
            ST_SQR_WAIT: begin
                if (mul_done) begin
                    if (mul_product == 32'd1 && acc_reg != 32'd1 && acc_reg != nm1_reg)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SQR;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready   = 1'b0;
        mul_start = 1'b0;
        mul_a     = acc_reg;
        mul_b     = base_reg;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_POW: begin
                if (e_reg != '0) begin
                    mul_start = 1'b1;
                    if (!e_reg[0]) mul_a = base_reg;
                end
            end
            ST_POW_SQ: begin
                mul_start = 1'b1;
                mul_a     = base_reg;
            end
            ST_SQR: begin
                if (j_reg != s_reg) begin
                    mul_start = 1'b1;
                    mul_b     = acc_reg;
                end
            end
            ST_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (out_load) m_is_prime_reg <= verdict_reg;
        case (state_reg)
            ST_IDLE: begin
                n_reg <= s_candidate;
            end
            ST_CLASSIFY: begin
                verdict_reg <= (n_reg == 32'd2);
                nm1_reg     <= n_reg - 32'd1;
                d_reg       <= n_reg - 32'd1;
                s_reg       <= '0;
                wit_idx_reg <= '0;
            end
            ST_FACTOR: begin
                if (!d_reg[0]) begin
                    d_reg <= {1'b0, d_reg[DATA_W-1:1]};
                    s_reg <= s_reg + 1'b1;
                end
            end
            ST_WIT: begin
                if (wit_idx_reg == WIT_W'(WIT_COUNT)) begin
                    verdict_reg <= 1'b1;
                end else if (wit_val < n_reg) begin
                    acc_reg  <= 32'd1;
                    base_reg <= wit_val;
                    e_reg    <= d_reg;
                    j_reg    <= '0;
                end else begin
                    wit_idx_reg <= wit_idx_reg + 1'b1;
                end
            end
            ST_POW_MWAIT: begin
                if (mul_done) acc_reg <= mul_product;
            end
            ST_POW_SWAIT: begin
                if (mul_done) begin
                    base_reg <= mul_product;
                    e_reg    <= {1'b0, e_reg[DATA_W-1:1]};
                end
            end
            ST_SQR: begin
                if (j_reg == s_reg) begin
                    verdict_reg <= 1'b0;
                    wit_idx_reg <= wit_idx_reg + 1'b1;
                end
            end
            ST_SQR_WAIT: begin
                if (mul_done) begin
                    verdict_reg <= 1'b0;
                    acc_reg     <= mul_product;
                    j_reg       <= j_reg + 1'b1;
                end
            end
            default: begin
                verdict_reg <= verdict_reg;
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_is_prime_reg;

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the 32-bit Miller-Rabin prime tester.
`timescale 1ns / 1ps

module tb;
    import mrp_pkg::*;

    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int IDLE_PCT     = 29;
    localparam int N_RANDOM     = 77;
    localparam int N_PROBES     = 23;
    localparam int N_SPSP       = 12;
    localparam int TAIL_CYCLES  = 50;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        word_t cand;
        bit    typed;    // verdict written in below rather than predicted
        bit    verdict;
    } probe_t;

    logic  aclk;
    logic  aresetn     = 1'b0;
    logic  s_valid     = 1'b0;
    logic  s_ready;
    word_t s_candidate = '0;
    logic  m_valid;
    logic  m_ready     = 1'b0;
    logic  m_is_prime;

    bit          verdict_q[$];
    bit          full_rate   = 1'b0;
    int unsigned cycles      = 0;
    int unsigned n_sent      = 0;
    int unsigned n_checked   = 0;
    int unsigned n_primes    = 0;
    int unsigned n_mismatch  = 0;

    // Boundaries, witness skipping, strong pseudoprimes and Carmichael numbers
    probe_t probes [N_PROBES] = '{
        '{32'd0,          1'b1, 1'b0},
        '{32'd1,          1'b1, 1'b0},
        '{32'd2,          1'b1, 1'b1},
        '{32'd3,          1'b1, 1'b1},
        '{32'd4,          1'b1, 1'b0},
        '{32'd5,          1'b0, 1'b0},
        '{32'd7,          1'b0, 1'b0},
        '{32'd9,          1'b0, 1'b0},
        '{32'd61,         1'b0, 1'b0},
        '{32'd62,         1'b0, 1'b0},
        '{32'd63,         1'b0, 1'b0},
        '{32'd561,        1'b0, 1'b0},
        '{32'd1105,       1'b0, 1'b0},
        '{32'd2047,       1'b0, 1'b0},
        '{32'd3277,       1'b0, 1'b0},
        '{32'd65537,      1'b0, 1'b0},
        '{32'd25326001,   1'b0, 1'b0},
        '{32'd3215031751, 1'b0, 1'b0},
        '{32'h8000_0000,  1'b1, 1'b0},
        '{32'h8000_0001,  1'b0, 1'b0},
        '{32'hAAAA_AAAB,  1'b0, 1'b0},
        '{32'd4294967291, 1'b1, 1'b1},
        '{32'hFFFF_FFFF,  1'b1, 1'b0}
    };

    word_t spsp [N_SPSP] = '{
        32'd2047, 32'd3277, 32'd4033, 32'd4681, 32'd8321, 32'd561,
        32'd1729, 32'd41041, 32'd825265, 32'd15841, 32'd25326001, 32'd3215031751
    };

    miller_rabin_prime_test_32 uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_candidate (s_candidate),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_prime  (m_is_prime)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic word_t mulmod(word_t x, word_t y, word_t m);
        longint unsigned prod;
        prod = longint'(x) * longint'(y);
        return word_t'(prod % longint'(m));
    endfunction

    function automatic word_t powmod(word_t base, word_t e, word_t m);
        word_t acc;
        word_t b;
        acc = 32'd1 % m;
        b   = base % m;
        while (e != 0) begin
            if (e[0])
                acc = mulmod(acc, b, m);
            b = mulmod(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit mr_verdict(word_t n);
        word_t d;
        word_t x;
        word_t y;
        int    s;
        if (n < 2)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        foreach (WITNESS[i]) begin
            if (WITNESS[i] >= n)
                continue;
            x = powmod(WITNESS[i], d, n);
            y = x;
            for (int j = 0; j < s; j++) begin
                y = mulmod(x, x, n);
                // a nontrivial square root of one proves a composite
                if (y == 1 && x != 1 && x != n - 1)
                    return 1'b0;
                x = y;
            end
            if (y != 1)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic word_t rand_bits(int lo_w, int hi_w);
        int w;
        w = $urandom_range(hi_w, lo_w);
        return word_t'($urandom) >> (DATA_W - w);
    endfunction

    function automatic word_t prime_from(word_t start);
        word_t c;
        c = (start > 32'hFFFF_0000) ? 32'hFFFF_0000 : start;
        c = (c < 3) ? 32'd3 : (c | 32'd1);
        while (!mr_verdict(c))
            c += 2;
        return c;
    endfunction

    task automatic send(word_t cand, bit verdict);
        while (!full_rate && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_candidate <= cand;
        do @(posedge aclk); while (!s_ready);
        verdict_q.push_back(verdict);
        n_sent++;
    endtask

    // Result side: random back-pressure, none while full_rate is set
    always @(posedge aclk)
        m_ready <= full_rate || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("ERROR: result %0b with no item outstanding", m_is_prime);
            end else begin
                bit want;
                want = verdict_q.pop_front();
                n_checked++;
                if (m_is_prime === 1'b1)
                    n_primes++;
                if (m_is_prime !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("ERROR: result %0d is_prime expected %0b got %0b",
                                 n_checked, want, m_is_prime);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, verdict_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        word_t cand;
        int    pick;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probes[i])
            send(probes[i].cand,
                 probes[i].typed ? probes[i].verdict : mr_verdict(probes[i].cand));

        for (int k = 0; k < N_RANDOM; k++) begin
            full_rate = (k >= 30 && k < 55);
            pick = $urandom_range(99);
            if (pick < 25)
                cand = prime_from(rand_bits(2, 32));
            else if (pick < 45)
                cand = prime_from(word_t'($urandom_range(65500, 3)))
                     * prime_from(word_t'($urandom_range(65500, 3)));
            else if (pick < 55)
                cand = spsp[$urandom_range(N_SPSP - 1)];
            else if (pick < 90)
                cand = rand_bits(2, 32) | 32'd1;
            else if (pick < 95)
                cand = word_t'($urandom);
            else
                cand = word_t'($urandom_range(4));
            send(cand, mr_verdict(cand));
        end
        full_rate = 1'b0;
        s_valid <= 1'b0;

        // drain, then give the block a little time to misbehave
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Tested %0d candidates (%0d directed), %0d reported prime",
                 n_sent, N_PROBES, n_primes);
        $display("Checked %0d results in %0d cycles, %0d mismatches",
                 n_checked, cycles, n_mismatch);
        if (n_mismatch == 0 && verdict_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
